>>> sv/voxel_ray_traversal_unit_macros.svh
// Assertion macros for the voxel ray traversal unit.
`ifndef VOXEL_RAY_TRAVERSAL_UNIT_MACROS_SVH
`define VOXEL_RAY_TRAVERSAL_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Types and constants shared by the voxel ray traversal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vrt_pkg;

    localparam int CRD_W    = 16;
    localparam int IDX_W    = 8;
    localparam int T_W      = 32;
    localparam int VS_W     = 5;
    localparam int NUM_AXES = 3;
    localparam logic [T_W-1:0] T_SAT = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_EMIT
    } vrt_state_t;

    // Divider operation per axis
    typedef enum logic [1:0] {
        OP_IDX_S,
        OP_IDX_E,
        OP_TNEXT,
        OP_TSTEP
    } div_op_t;

    typedef struct packed {
        logic       capture;
        logic       div_start;
        logic       div_store;
        logic       emit;
        div_op_t    op;
        logic [1:0] axis;
    } vrt_cmd_t;

    typedef struct packed {
        logic                div_done;
        logic [NUM_AXES-1:0] flat;
        logic                last_now;
    } vrt_status_t;

endpackage

`default_nettype wire

>>> sv/voxel_ray_traversal_unit.sv
// Setup runs six index divisions and up to six t divisions of NW quotient bits
//   (NW = 6 + COORD_FRAC_BITS + T_FRAC_BITS, 38 by default) on the one shared
//   radix-2 divider.
// Then one voxel word per cycle, up to MAX_RUN words.
// One ray at a time; output never stalls.
// Reset: asynchronous active low; clears control, voxel_size returns to 1.
// ----------------------------------------------------------------------------
// voxel_ray_traversal_unit
// 3D DDA voxel traversal: emits the voxel indices a ray passes, in order, up to MAX_RUN.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_ray_traversal_unit_macros.svh"

module voxel_ray_traversal_unit #(
    parameter int MAX_RUN         = 64,
    parameter int COORD_FRAC_BITS = 8,
    parameter int T_FRAC_BITS     = 24
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      voxel_size_we,
    input  wire logic [vrt_pkg::VS_W-1:0]  voxel_size,
    input  wire logic [vrt_pkg::CRD_W-1:0] start_x,
    input  wire logic [vrt_pkg::CRD_W-1:0] start_y,
    input  wire logic [vrt_pkg::CRD_W-1:0] start_z,
    input  wire logic [vrt_pkg::CRD_W-1:0] end_x,
    input  wire logic [vrt_pkg::CRD_W-1:0] end_y,
    input  wire logic [vrt_pkg::CRD_W-1:0] end_z,
    output logic                           voxel_valid,
    output logic [vrt_pkg::IDX_W-1:0]      voxel_x,
    output logic [vrt_pkg::IDX_W-1:0]      voxel_y,
    output logic [vrt_pkg::IDX_W-1:0]      voxel_z,
    output logic                           last_voxel_flag,
    output logic                           truncated
);

    import vrt_pkg::*;

    vrt_cmd_t    cmd;
    vrt_status_t status;

    vrt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    vrt_datapath #(
        .MAX_RUN         (MAX_RUN),
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .T_FRAC_BITS     (T_FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .voxel_size_we   (voxel_size_we),
        .voxel_size      (voxel_size),
        .start_x         (start_x),
        .start_y         (start_y),
        .start_z         (start_z),
        .end_x           (end_x),
        .end_y           (end_y),
        .end_z           (end_z),
        .voxel_valid     (voxel_valid),
        .voxel_x         (voxel_x),
        .voxel_y         (voxel_y),
        .voxel_z         (voxel_z),
        .last_voxel_flag (last_voxel_flag),
        .truncated       (truncated)
    );

    // More words of the run follow while busy
    `VRT_ASSERT_IMP(a_mid_busy, clk, rst_n, voxel_valid && !last_voxel_flag, busy, "mid word idle")
    // Truncation only flags the final word
    `VRT_ASSERT_IMP(a_trunc_last, clk, rst_n, voxel_valid && truncated, last_voxel_flag, "early trunc")
    // Accepted ray starts work
    `VRT_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy && !voxel_valid, "ray not started")

endmodule

`default_nettype wire

>>> sv/vrt_divider.sv
// ----------------------------------------------------------------------------
// vrt_divider
// Restoring radix-2 divider, one quotient bit per cycle, iteration count set
// per operation (numerator is left aligned).
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_divider #(
    parameter int NW = 38,
    parameter int DW = 16,
    parameter int IW = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [IW-1:0] iters,
    output logic               done,
    output logic [NW-1:0]      quo,
    output logic [DW-1:0]      rem
);

    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [IW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                run_reg <= 1'b1;
                cnt_reg <= iters;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == IW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Data
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> sv/vrt_datapath.sv
// ----------------------------------------------------------------------------
// vrt_datapath
// Ray registers, setup divisions, DDA stepping and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_datapath #(
    parameter int MAX_RUN         = 64,
    parameter int COORD_FRAC_BITS = 8,
    parameter int T_FRAC_BITS     = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire vrt_pkg::vrt_cmd_t           cmd,
    output vrt_pkg::vrt_status_t             status,
    input  wire logic                        voxel_size_we,
    input  wire logic [vrt_pkg::VS_W-1:0]    voxel_size,
    input  wire logic [vrt_pkg::CRD_W-1:0]   start_x,
    input  wire logic [vrt_pkg::CRD_W-1:0]   start_y,
    input  wire logic [vrt_pkg::CRD_W-1:0]   start_z,
    input  wire logic [vrt_pkg::CRD_W-1:0]   end_x,
    input  wire logic [vrt_pkg::CRD_W-1:0]   end_y,
    input  wire logic [vrt_pkg::CRD_W-1:0]   end_z,
    output logic                             voxel_valid,
    output logic [vrt_pkg::IDX_W-1:0]        voxel_x,
    output logic [vrt_pkg::IDX_W-1:0]        voxel_y,
    output logic [vrt_pkg::IDX_W-1:0]        voxel_z,
    output logic                             last_voxel_flag,
    output logic                             truncated
);

    import vrt_pkg::*;

    localparam int CW     = VS_W + COORD_FRAC_BITS;
    localparam int NW_RAW = CW + 1 + T_FRAC_BITS;
    localparam int NW     = (NW_RAW > CRD_W) ? NW_RAW : CRD_W;
    localparam int DW     = (CW > CRD_W) ? CW : CRD_W;
    localparam int IW     = $clog2(NW + 1);
    localparam int QW     = (NW > T_W) ? NW : T_W + 1;
    localparam int CNT_W  = $clog2(MAX_RUN + 1);

    // Configuration and captured ray
    logic [VS_W-1:0]  vs_reg;
    logic [CRD_W-1:0] s_reg [NUM_AXES];
    logic [CRD_W-1:0] e_reg [NUM_AXES];

    // Traversal state
    logic [IDX_W-1:0] cur_reg   [NUM_AXES];
    logic [IDX_W-1:0] endv_reg  [NUM_AXES];
    logic [T_W-1:0]   tnext_reg [NUM_AXES];
    logic [T_W-1:0]   tstep_reg [NUM_AXES];
    logic [CW-1:0]    rems_reg  [NUM_AXES];
    logic [NUM_AXES-1:0] neg_reg;
    logic [CNT_W-1:0] count_reg;
    logic             first_reg;

    // Result word
    logic             valid_reg;
    logic [IDX_W-1:0] vx_reg, vy_reg, vz_reg;
    logic             last_reg, trunc_reg;

    logic [VS_W-1:0]  vs_eff;
    logic [CW-1:0]    cell_len;
    logic [CRD_W-1:0] s_sel, e_sel, absd;
    logic [CW:0]      near_num;
    logic [NW-1:0]    div_num;
    logic [DW-1:0]    div_den;
    logic [IW-1:0]    div_iters;
    logic             div_done;
    logic [NW-1:0]    div_quo;
    logic [DW-1:0]    div_rem;
    logic [QW-1:0]    q_ext;
    logic [T_W-1:0]   q_sat;

    logic [NUM_AXES-1:0] pre_ax;
    logic [NUM_AXES-1:0] flat;
    logic                pre;
    logic                at_end;
    logic                last_now;
    logic [1:0]          ax;
    logic [T_W:0]        tsum;
    logic [T_W-1:0]      tadd;

    // Operand selection
    always_comb
    begin
        vs_eff   = (vs_reg == '0) ? VS_W'(1) : vs_reg;
        cell_len = CW'(vs_eff) << COORD_FRAC_BITS;
        s_sel    = s_reg[cmd.axis];
        e_sel    = e_reg[cmd.axis];
        absd     = (e_sel > s_sel) ? e_sel - s_sel : s_sel - e_sel;
        near_num = neg_reg[cmd.axis] ? {1'b0, cell_len} + {1'b0, rems_reg[cmd.axis]}
                                     : {1'b0, cell_len} - {1'b0, rems_reg[cmd.axis]};
        unique case (cmd.op)
            OP_IDX_S:
            begin
                div_num   = NW'(s_sel) << (NW - CRD_W);
                div_den   = DW'(cell_len);
                div_iters = IW'(CRD_W);
            end
            OP_IDX_E:
            begin
                div_num   = NW'(e_sel) << (NW - CRD_W);
                div_den   = DW'(cell_len);
                div_iters = IW'(CRD_W);
            end
            OP_TNEXT:
            begin
                div_num   = NW'(near_num) << T_FRAC_BITS;
                div_den   = DW'(absd);
                div_iters = IW'(NW);
            end
            default:
            begin
                div_num   = NW'(cell_len) << T_FRAC_BITS;
                div_den   = DW'(absd);
                div_iters = IW'(NW);
            end
        endcase
    end

    vrt_divider #(
        .NW (NW),
        .DW (DW),
        .IW (IW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .iters (div_iters),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // Saturate quotient to Q8.24 range
    always_comb
    begin
        q_ext = QW'(div_quo);
        q_sat = (|q_ext[QW-1:T_W]) ? T_SAT : q_ext[T_W-1:0];
    end

    // Stepping decisions
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pre_ax[a] = neg_reg[a] && (cur_reg[a] != endv_reg[a]);
            flat[a]   = (s_reg[a] == e_reg[a]);
        end
        pre    = |pre_ax;
        at_end = (cur_reg[0] == endv_reg[0]) && (cur_reg[1] == endv_reg[1]) &&
                 (cur_reg[2] == endv_reg[2]);
        last_now = at_end || (count_reg == CNT_W'(MAX_RUN - 1));
        if (tnext_reg[0] < tnext_reg[1])
            ax = (tnext_reg[0] < tnext_reg[2]) ? 2'd0 : 2'd2;
        else
            ax = (tnext_reg[1] < tnext_reg[2]) ? 2'd1 : 2'd2;
        tsum = {1'b0, tnext_reg[ax]} + {1'b0, tstep_reg[ax]};
        tadd = tsum[T_W] ? T_SAT : tsum[T_W-1:0];
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vs_reg <= VS_W'(1);
        else if (voxel_size_we)
            vs_reg <= voxel_size;
    end

    // Control state of the run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            first_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.capture)
            begin
                count_reg <= '0;
                first_reg <= 1'b1;
            end
            else if (cmd.emit)
            begin
                count_reg <= count_reg + 1'b1;
                first_reg <= 1'b0;
            end
        end
    end

    // Ray data and traversal registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            s_reg[0] <= start_x;
            s_reg[1] <= start_y;
            s_reg[2] <= start_z;
            e_reg[0] <= end_x;
            e_reg[1] <= end_y;
            e_reg[2] <= end_z;
        end
        if (cmd.div_store)
        begin
            case (cmd.op)
                OP_IDX_S:
                begin
                    cur_reg[cmd.axis]  <= div_quo[IDX_W-1:0];
                    rems_reg[cmd.axis] <= div_rem[CW-1:0];
                end
                OP_IDX_E:
                begin
                    endv_reg[cmd.axis] <= div_quo[IDX_W-1:0];
                    neg_reg[cmd.axis]  <= e_sel < s_sel;
                    if (flat[cmd.axis])
                    begin
                        tnext_reg[cmd.axis] <= T_SAT;
                        tstep_reg[cmd.axis] <= T_SAT;
                    end
                end
                OP_TNEXT: tnext_reg[cmd.axis] <= q_sat;
                default:  tstep_reg[cmd.axis] <= q_sat;
            endcase
        end
        if (cmd.emit)
        begin
            vx_reg    <= cur_reg[0];
            vy_reg    <= cur_reg[1];
            vz_reg    <= cur_reg[2];
            last_reg  <= last_now;
            trunc_reg <= last_now && !at_end;
            if (first_reg && pre)
            begin
                // diagonal pre-step on negative axes
                for (int a = 0; a < NUM_AXES; a++)
                    if (pre_ax[a])
                        cur_reg[a] <= cur_reg[a] - 1'b1;
            end
            else
            begin
                cur_reg[ax]   <= neg_reg[ax] ? cur_reg[ax] - 1'b1 : cur_reg[ax] + 1'b1;
                tnext_reg[ax] <= tadd;
            end
        end
    end

    always_comb
    begin
        status.div_done = div_done;
        status.flat     = flat;
        status.last_now = last_now;
    end

    assign voxel_valid     = valid_reg;
    assign voxel_x         = vx_reg;
    assign voxel_y         = vy_reg;
    assign voxel_z         = vz_reg;
    assign last_voxel_flag = last_reg;
    assign truncated       = trunc_reg;

endmodule

`default_nettype wire

>>> sv/vrt_ctrl.sv
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: capture, per-axis setup divisions, then one voxel per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vrt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    output vrt_pkg::vrt_cmd_t         cmd,
    input  wire vrt_pkg::vrt_status_t status
);

    import vrt_pkg::*;

    vrt_state_t state_reg, state_next;
    div_op_t    op_reg, op_next;
    logic [1:0] axis_reg, axis_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_IDX_S;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            axis_reg  <= axis_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        axis_next     = axis_reg;
        cmd.capture   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_store = 1'b0;
        cmd.emit      = 1'b0;
        cmd.op        = op_reg;
        cmd.axis      = axis_reg;
        busy          = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    op_next     = OP_IDX_S;
                    axis_next   = 2'd0;
                    state_next  = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = ST_DIV_LOAD;
                    unique case (op_reg)
                        OP_IDX_S: op_next = OP_IDX_E;
                        OP_TNEXT: op_next = OP_TSTEP;
                        default:
                        begin
                            if (op_reg == OP_IDX_E && !status.flat[axis_reg])
                                op_next = OP_TNEXT;
                            else
                            begin
                                op_next = OP_IDX_S;
                                if (axis_reg == 2'd2)
                                    state_next = ST_EMIT;
                                else
                                    axis_next = axis_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                cmd.emit = 1'b1;
                if (status.last_now)
                    state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> verif/tb_voxel_ray_traversal_unit.sv
// ----------------------------------------------------------------------------
// tb_voxel_ray_traversal_unit
// Drives rays into the voxel traversal unit and checks every voxel word
// against a local DDA predictor, over several voxel sizes and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voxel_ray_traversal_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import vrt_pkg::*;

    localparam int RUN_CAP      = 64;
    localparam int CRD_FRAC     = 8;
    localparam int TFRAC        = 24;
    localparam int CYCLE_LIMIT  = 900000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [IDX_W-1:0] vx;
        logic [IDX_W-1:0] vy;
        logic [IDX_W-1:0] vz;
        logic             last;
        logic             trunc;
    } voxel_word_t;

    typedef struct {
        logic [CRD_W-1:0] s[3];
        logic [CRD_W-1:0] e[3];
        bit               has_exp;
        logic [IDX_W-1:0] ev[3];
    } ray_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic vs_we;
    logic [VS_W-1:0] vs_data;
    logic [CRD_W-1:0] sx, sy, sz, ex, ey, ez;
    logic voxel_valid;
    logic [IDX_W-1:0] voxel_x, voxel_y, voxel_z;
    logic last_voxel_flag, truncated;

    voxel_word_t expected_voxels[$];
    logic [VS_W-1:0] cur_voxel_size;
    int  send_idle_pct;
    int  errors;
    int  rays_sent;
    int  words_seen;
    int  cycles;
    ray_row_t ray_table[$];

    voxel_ray_traversal_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .voxel_size_we  (vs_we),
        .voxel_size     (vs_data),
        .start_x        (sx),
        .start_y        (sy),
        .start_z        (sz),
        .end_x          (ex),
        .end_y          (ey),
        .end_z          (ez),
        .voxel_valid    (voxel_valid),
        .voxel_x        (voxel_x),
        .voxel_y        (voxel_y),
        .voxel_z        (voxel_z),
        .last_voxel_flag(last_voxel_flag),
        .truncated      (truncated)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Cycle watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [T_W-1:0] sat_div(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = num / den;
        return (q > 64'hFFFF_FFFF) ? T_SAT : q[T_W-1:0];
    endfunction

    // Queue one expected word
    task automatic add_word(input voxel_word_t w);
        expected_voxels = {expected_voxels, w};
    endtask

    // Queue one directed row
    task automatic add_row(input ray_row_t r);
        ray_table = {ray_table, r};
    endtask

    // DDA predictor: appends the voxel words of one ray, returns its first word
    task automatic predict_ray_voxels(input logic [CRD_W-1:0] s[3],
                                      input logic [CRD_W-1:0] e[3],
                                      output voxel_word_t first_w);
        longint unsigned vsz, cellw, cs, ce, d, num;
        logic [IDX_W-1:0] cur[3], fin[3];
        logic [T_W-1:0] tn[3], ts[3];
        logic [T_W:0] sum;
        bit neg[3];
        bit pre;
        int cnt, ax;
        voxel_word_t w;
        vsz = (cur_voxel_size == 0) ? 1 : cur_voxel_size;
        cellw = vsz << CRD_FRAC;
        pre = 0;
        for (int a = 0; a < 3; a++)
        begin
            cs = s[a] / cellw;
            ce = e[a] / cellw;
            cur[a] = cs[IDX_W-1:0];
            fin[a] = ce[IDX_W-1:0];
            neg[a] = 0;
            if (e[a] == s[a])
            begin
                tn[a] = T_SAT;
                ts[a] = T_SAT;
            end
            else if (e[a] > s[a])
            begin
                d = e[a] - s[a];
                num = (cs + 1) * cellw - s[a];
                tn[a] = sat_div(num << TFRAC, d);
                ts[a] = sat_div(cellw << TFRAC, d);
            end
            else
            begin
                d = s[a] - e[a];
                num = s[a] + cellw - cs * cellw;
                neg[a] = 1;
                tn[a] = sat_div(num << TFRAC, d);
                ts[a] = sat_div(cellw << TFRAC, d);
            end
        end
        w = '{cur[0], cur[1], cur[2], 1'b0, 1'b0};
        first_w = w;
        add_word(w);
        cnt = 1;
        for (int a = 0; a < 3; a++)
            if (neg[a] && cur[a] != fin[a])
                pre = 1;
        // Diagonal pre-step on negative axes
        if (pre)
        begin
            for (int a = 0; a < 3; a++)
                if (neg[a] && cur[a] != fin[a])
                    cur[a] = cur[a] - 1'b1;
            w = '{cur[0], cur[1], cur[2], 1'b0, 1'b0};
            add_word(w);
            cnt++;
        end
        while (!(cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]) && cnt < RUN_CAP)
        begin
            if (tn[0] < tn[1])
                ax = (tn[0] < tn[2]) ? 0 : 2;
            else
                ax = (tn[1] < tn[2]) ? 1 : 2;
            cur[ax] = neg[ax] ? cur[ax] - 1'b1 : cur[ax] + 1'b1;
            sum = tn[ax] + ts[ax];
            tn[ax] = sum[T_W] ? T_SAT : sum[T_W-1:0];
            w = '{cur[0], cur[1], cur[2], 1'b0, 1'b0};
            add_word(w);
            cnt++;
        end
        w = expected_voxels.pop_back();
        w.last = 1'b1;
        w.trunc = !(cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]);
        add_word(w);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        voxel_word_t exp_w;
        if (rst_n && voxel_valid)
        begin
            words_seen++;
            if (expected_voxels.size() == 0)
            begin
                $error("unexpected voxel word %0d,%0d,%0d", voxel_x, voxel_y, voxel_z);
                errors++;
            end
            else
            begin
                exp_w = expected_voxels.pop_front();
                if (voxel_x !== exp_w.vx)
                begin
                    $error("voxel_x expected %0d actual %0d", exp_w.vx, voxel_x);
                    errors++;
                end
                if (voxel_y !== exp_w.vy)
                begin
                    $error("voxel_y expected %0d actual %0d", exp_w.vy, voxel_y);
                    errors++;
                end
                if (voxel_z !== exp_w.vz)
                begin
                    $error("voxel_z expected %0d actual %0d", exp_w.vz, voxel_z);
                    errors++;
                end
                if (last_voxel_flag !== exp_w.last)
                begin
                    $error("last_voxel_flag expected %0b actual %0b", exp_w.last,
                           last_voxel_flag);
                    errors++;
                end
                if (truncated !== exp_w.trunc)
                begin
                    $error("truncated expected %0b actual %0b", exp_w.trunc, truncated);
                    errors++;
                end
            end
        end
    end

    // Wait for all words, then settle
    task automatic drain();
        while (expected_voxels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_voxel_size(input logic [VS_W-1:0] v);
        vs_we = 1'b1;
        vs_data = v;
        @(negedge clk);
        vs_we = 1'b0;
        cur_voxel_size = v;
    endtask

    // Send one ray; called at a falling edge. Optional check of the predicted start voxel.
    task automatic send_ray(input ray_row_t r);
        voxel_word_t first_w;
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        sx = r.s[0]; sy = r.s[1]; sz = r.s[2];
        ex = r.e[0]; ey = r.e[1]; ez = r.e[2];
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_ray_voxels(r.s, r.e, first_w);
        if (r.has_exp)
        begin
            if (first_w.vx !== r.ev[0] || first_w.vy !== r.ev[1] || first_w.vz !== r.ev[2])
            begin
                $error("start voxel expected %0d,%0d,%0d actual %0d,%0d,%0d",
                       r.ev[0], r.ev[1], r.ev[2], first_w.vx, first_w.vy, first_w.vz);
                errors++;
            end
        end
        rays_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    function automatic ray_row_t mk_row(int x0, int y0, int z0, int x1, int y1, int z1,
                                        bit he, int vx, int vy, int vz);
        ray_row_t r;
        r.s[0] = CRD_W'(x0); r.s[1] = CRD_W'(y0); r.s[2] = CRD_W'(z0);
        r.e[0] = CRD_W'(x1); r.e[1] = CRD_W'(y1); r.e[2] = CRD_W'(z1);
        r.has_exp = he;
        r.ev[0] = IDX_W'(vx); r.ev[1] = IDX_W'(vy); r.ev[2] = IDX_W'(vz);
        return r;
    endfunction

    // Mostly short rays so runs end; some long ones hit the cap
    function automatic ray_row_t rand_ray();
        ray_row_t r;
        int span;
        span = ($urandom_range(9) == 0) ? 65535 :
               int'($urandom_range(6)) * 256 * int'(cur_voxel_size);
        for (int a = 0; a < 3; a++)
        begin
            r.s[a] = CRD_W'($urandom);
            case ($urandom_range(5))
                0: r.e[a] = r.s[a];
                1: r.e[a] = CRD_W'($urandom);
                default: r.e[a] = CRD_W'(int'(r.s[a]) + int'($urandom_range(span)) - span / 2);
            endcase
        end
        r.has_exp = 0;
        return r;
    endfunction

    initial
    begin
        logic [VS_W-1:0] sizes[5];
        errors = 0; rays_sent = 0; words_seen = 0; cycles = 0;
        cur_voxel_size = 1;
        send_idle_pct = 10;
        rst_n = 1'b0; start = 1'b0; vs_we = 1'b0; vs_data = '0;
        sx = '0; sy = '0; sz = '0; ex = '0; ey = '0; ez = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows: extremes, zero direction, diagonal ties, negative pre-step
        add_row(mk_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        add_row(mk_row(65535, 65535, 65535, 65535, 65535, 65535, 1, 255, 255, 255));
        add_row(mk_row(0, 0, 0, 1024, 0, 0, 1, 0, 0, 0));
        add_row(mk_row(0, 0, 0, 0, 1024, 0, 1, 0, 0, 0));
        add_row(mk_row(0, 0, 0, 0, 0, 1024, 1, 0, 0, 0));
        add_row(mk_row(0, 0, 0, 1024, 1024, 1024, 1, 0, 0, 0));
        add_row(mk_row(128, 128, 128, 1152, 1152, 128, 1, 0, 0, 0));
        add_row(mk_row(2048, 2048, 2048, 1024, 1024, 1024, 1, 8, 8, 8));
        add_row(mk_row(2048, 0, 0, 1024, 1024, 0, 1, 8, 0, 0));
        add_row(mk_row(0, 0, 0, 65535, 65535, 65535, 1, 0, 0, 0));
        add_row(mk_row(65535, 65535, 65535, 0, 0, 0, 1, 255, 255, 255));
        add_row(mk_row(65535, 0, 0, 0, 65535, 0, 1, 255, 0, 0));
        add_row(mk_row(300, 700, 900, 290, 700, 905, 0, 0, 0, 0));
        add_row(mk_row(43690, 21845, 52428, 13107, 43690, 4369, 0, 0, 0, 0));
        foreach (ray_table[i])
            send_ray(ray_table[i]);
        drain();

        // Voxel size extremes and zero, still directed
        write_voxel_size(5'd16);
        send_ray(mk_row(0, 0, 0, 65535, 65535, 65535, 1, 0, 0, 0));
        send_ray(mk_row(4095, 4096, 8191, 4096, 4095, 8192, 0, 0, 0, 0));
        drain();
        write_voxel_size(5'd0);
        send_ray(mk_row(255, 256, 0, 1280, 0, 512, 0, 0, 0, 0));
        drain();
        write_voxel_size(5'd31);
        send_ray(mk_row(0, 65535, 100, 65535, 0, 100, 0, 0, 0, 0));
        drain();

        // Random part: three idle phases across several voxel sizes
        sizes = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31};
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 65 : 0;
            for (int k = 0; k < 5; k++)
            begin
                drain();
                write_voxel_size((k == 4 || ph == 2) ? 5'($urandom_range(31)) : sizes[k]);
                for (int n = 0; n < 17; n++)
                begin
                    send_ray(rand_ray());
                    if (n == 8)
                        drain();
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d rays, checked %0d voxel words over voxel sizes 0..31.",
                 rays_sent, words_seen);
        if (errors == 0 && expected_voxels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
